FILE: hdl/cbc_pkg.sv
// Package for the cartridge bank controller: transaction types, target and
// kind codes, register indexes and bus address region limits.
// No dependencies.
`default_nettype none

package cbc_pkg;

  // Field widths of the transactions
  localparam int unsigned BUS_ADDR_W = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ROM_ADDR_W = 21;
  localparam int unsigned RAM_ADDR_W = 15;
  localparam int unsigned TARGET_W   = 2;

  // Default address widths of the attached memories
  localparam int unsigned ROM_ADDR_BITS_DEF = 21;
  localparam int unsigned RAM_ADDR_BITS_DEF = 15;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CART_KIND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROM_SIZE  = 1'd1;

  // Cartridge kinds
  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_MBC1  = 2'd1;

  // Access kinds
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Result targets
  localparam logic [TARGET_W-1:0] TGT_ROM_READ  = 2'd0;
  localparam logic [TARGET_W-1:0] TGT_RAM_READ  = 2'd1;
  localparam logic [TARGET_W-1:0] TGT_RAM_WRITE = 2'd2;
  localparam logic [TARGET_W-1:0] TGT_NONE      = 2'd3;

  // Bus region limits
  localparam logic [BUS_ADDR_W-1:0] ADDR_BANK_LOW  = 16'h2000;
  localparam logic [BUS_ADDR_W-1:0] ADDR_ROM_UPPER = 16'h4000;
  localparam logic [BUS_ADDR_W-1:0] ADDR_MODE      = 16'h6000;
  localparam logic [BUS_ADDR_W-1:0] ADDR_RAM       = 16'h8000;
  localparam logic [BUS_ADDR_W-1:0] ADDR_ABOVE_RAM = 16'hC000;

  // Register values
  localparam logic [3:0]        RAM_GATE_OPEN = 4'hA;
  localparam logic [BYTE_W-1:0] OPEN_BUS_BYTE = 8'hFF;
  localparam logic [4:0]        BANK_LOW_RST  = 5'd1;
  localparam logic [4:0]        ROM_SIZE_RST  = 5'd21;

  typedef struct packed {
    logic                  action;
    logic [BUS_ADDR_W-1:0] address;
    logic [BYTE_W-1:0]     write_data;
  } cbc_in_t;

  typedef struct packed {
    logic [TARGET_W-1:0]   target;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [RAM_ADDR_W-1:0] ram_address;
    logic [BYTE_W-1:0]     ram_data;
    logic [BYTE_W-1:0]     fixed_value;
  } cbc_out_t;

  typedef struct packed {
    logic [1:0] cart_kind;
    logic [4:0] rom_size_log2;
  } cbc_cfg_t;

endpackage

`default_nettype wire

FILE: hdl/cbc_xlate.sv
// Banking registers and address translation of one bus transaction.
// Depends on cbc_pkg.
`default_nettype none

module cbc_xlate import cbc_pkg::*; #(
  parameter int unsigned ROM_ADDR_BITS = ROM_ADDR_BITS_DEF,
  parameter int unsigned RAM_ADDR_BITS = RAM_ADDR_BITS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     acc_i,
  input  wire cbc_in_t  item_i,
  input  wire cbc_cfg_t cfg_i,
  output cbc_out_t      res_o
);

  localparam logic [ROM_ADDR_W-1:0] ROM_ONES = '1;
  localparam logic [RAM_ADDR_W-1:0] RAM_ONES = '1;
  localparam logic [ROM_ADDR_W-1:0] ROM_PASS_MASK =
    ~(ROM_ONES << ROM_ADDR_BITS);
  localparam logic [RAM_ADDR_W-1:0] RAM_MASK = ~(RAM_ONES << RAM_ADDR_BITS);
  localparam logic [4:0] ROM_BITS_MAX = 5'(ROM_ADDR_BITS);

  logic [3:0] ram_gate_q, ram_gate_d;
  logic [4:0] bank_low_q, bank_low_d;
  logic [1:0] bank_high_q, bank_high_d;
  logic       mode_q, mode_d;

  logic [4:0]            rom_bits;
  logic [ROM_ADDR_W-1:0] rom_mask;
  logic [6:0]            rom_bank_lo;
  logic [6:0]            rom_bank_hi;
  logic [1:0]            ram_bank;
  logic [RAM_ADDR_W-1:0] ram_addr;
  logic                  gate_open;
  logic                  is_write;
  logic [BUS_ADDR_W-1:0] addr;
  logic [BYTE_W-1:0]     data;

  // Saturate the configured ROM size and build its mask
  assign rom_bits = (cfg_i.rom_size_log2 > ROM_BITS_MAX) ? ROM_BITS_MAX
                                                         : cfg_i.rom_size_log2;
  assign rom_mask = ~(ROM_ONES << rom_bits);

  assign addr        = item_i.address;
  assign data        = item_i.write_data;
  assign is_write    = (item_i.action == ACT_WRITE);
  assign gate_open   = (ram_gate_q == RAM_GATE_OPEN);
  assign rom_bank_lo = mode_q ? {bank_high_q, 5'd0} : 7'd0;
  assign rom_bank_hi = {bank_high_q, bank_low_q};
  assign ram_bank    = mode_q ? bank_high_q : 2'd0;
  assign ram_addr    = {ram_bank, addr[12:0]} & RAM_MASK;

  // Translate the access and work out the register updates
  always_comb begin
    res_o       = '0;
    res_o.target = TGT_NONE;
    ram_gate_d  = ram_gate_q;
    bank_low_d  = bank_low_q;
    bank_high_d = bank_high_q;
    mode_d      = mode_q;
    unique case (cfg_i.cart_kind)
      KIND_PLAIN: begin
        if (!is_write) begin
          res_o.target      = TGT_ROM_READ;
          res_o.rom_address = {{(ROM_ADDR_W-BUS_ADDR_W){1'b0}}, addr} & ROM_PASS_MASK;
        end
      end
      KIND_MBC1: begin
        if (is_write) begin
          priority if (addr < ADDR_BANK_LOW) begin
            ram_gate_d = data[3:0];
          end else if (addr < ADDR_ROM_UPPER) begin
            bank_low_d = (data[4:0] == 5'd0) ? BANK_LOW_RST : data[4:0];
          end else if (addr < ADDR_MODE) begin
            bank_high_d = data[1:0];
          end else if (addr < ADDR_RAM) begin
            mode_d = data[0];
          end else if (addr < ADDR_ABOVE_RAM) begin
            if (gate_open) begin
              res_o.target      = TGT_RAM_WRITE;
              res_o.ram_address = ram_addr;
              res_o.ram_data    = data;
            end
          end else begin
            // drop writes above cartridge RAM
            res_o.target = TGT_NONE;
          end
        end else begin
          priority if (addr < ADDR_ROM_UPPER) begin
            res_o.target      = TGT_ROM_READ;
            res_o.rom_address = {rom_bank_lo, addr[13:0]} & rom_mask;
          end else if (addr < ADDR_RAM) begin
            res_o.target      = TGT_ROM_READ;
            res_o.rom_address = {rom_bank_hi, addr[13:0]} & rom_mask;
          end else if (addr < ADDR_ABOVE_RAM && gate_open) begin
            res_o.target      = TGT_RAM_READ;
            res_o.ram_address = ram_addr;
          end else begin
            res_o.fixed_value = OPEN_BUS_BYTE;
          end
        end
      end
      default: begin
        // unsupported kind: read zero, ignore writes
        res_o.target = TGT_NONE;
      end
    endcase
  end

  // Update banking registers on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_gate_q  <= '0;
      bank_low_q  <= BANK_LOW_RST;
      bank_high_q <= '0;
      mode_q      <= 1'b0;
    end else if (acc_i) begin
      ram_gate_q  <= ram_gate_d;
      bank_low_q  <= bank_low_d;
      bank_high_q <= bank_high_d;
      mode_q      <= mode_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cartridge_bank_controller.sv
// Cartridge bank controller: translates bus transactions to ROM/RAM addresses.
// A result is registered in the output register, or in the skid entry while the output is stalled.
// Throughput: one transaction per cycle; a two-entry output (register plus
// skid) keeps input open for one transaction while the output is stalled.
// Reset: asynchronous, active low; banking registers and configuration
// return to their power-up values and both output entries empty.
`default_nettype none

module cartridge_bank_controller import cbc_pkg::*; #(
  parameter int unsigned ROM_ADDR_BITS = ROM_ADDR_BITS_DEF,
  parameter int unsigned RAM_ADDR_BITS = RAM_ADDR_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration writes
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // bus transactions in
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire cbc_in_t               in_data_i,
  // results out
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output cbc_out_t                   out_data_o
);

  cbc_cfg_t cfg_q;
  cbc_out_t res;
  cbc_out_t out_q, skid_q;
  logic     out_valid_q, skid_valid_q;
  logic     in_acc, out_free;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cart_kind     <= KIND_MBC1;
      cfg_q.rom_size_log2 <= ROM_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IDX_CART_KIND: cfg_q.cart_kind     <= cfg_data_i[1:0];
        CFG_IDX_ROM_SIZE:  cfg_q.rom_size_log2 <= cfg_data_i[4:0];
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  cbc_xlate #(
    .ROM_ADDR_BITS (ROM_ADDR_BITS),
    .RAM_ADDR_BITS (RAM_ADDR_BITS)
  ) u_xlate (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (in_acc),
    .item_i (in_data_i),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Output register and skid entry control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || in_acc;
      skid_valid_q <= 1'b0;
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output register and skid entry payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= res;
      end
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // skid entry only fills behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while output register empty");

  // a transaction taken under output stall lands in the skid entry
  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("transaction lost under output stall");

  // only ROM reads carry a ROM address
  a_rom_addr_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.target != TGT_ROM_READ) |->
      (out_data_o.rom_address == '0))
    else $error("ROM address on a non-ROM result");

  // a fixed read value only comes with no memory access
  a_fixed_only_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.fixed_value != '0) |->
      (out_data_o.target == TGT_NONE))
    else $error("fixed value on a memory result");
`endif

endmodule

`default_nettype wire
